### rtl/tkdb_pkg.sv
// Package: payload types and fixed constants for the key debouncer / packet timer.
package tkdb_pkg;

  localparam int unsigned PktUnit      = 100;
  localparam int unsigned IntegW       = 7;
  localparam logic [IntegW-1:0] IntegMax = 7'd127;
  localparam int unsigned PktW         = 15;  // interval limit <= 255*100
  localparam logic [7:0]  PktDelayRst  = 8'd10;
  localparam logic [PktW-1:0] PktLimitRst = PktW'(PktDelayRst * PktUnit);

  typedef struct packed {
    logic        key0_level;
    logic        key1_level;
    logic        load_delay;
    logic [15:0] delay_count;
    logic        clear_rx_timeout;
    logic        clear_packet_flag;
  } tkdb_in_t;

  typedef struct packed {
    logic [1:0]  key_code;
    logic        window_end;
    logic        packet_flag;
    logic        delay_busy;
    logic [15:0] rx_timeout_count;
  } tkdb_out_t;

endpackage

### rtl/tick_key_debounce_packet_timer_top.sv
// Top level: tick-driven two-key integrating debouncer with packet and delay timers.
//
// Usage
//   Each input transaction is one millisecond tick carrying the raw levels of
//   two key pins (low = pressed) plus load/clear strobes for the timers. Every
//   tick yields exactly one output transaction with the debounced key code,
//   the window-end strobe, the sticky packet flag, delay busy and the receive
//   timeout tick count.
//   Both channels use valid/stall: a transaction moves on a rising edge with
//   valid high and stall low.
//   Path: input register, then update logic into the result register.
//   Throughput: 1 tick per cycle while out_stall_i is low; the only loop is
//   the state update in the result stage.
//   Stall: when out_stall_i holds a full result register, the input register
//   keeps one more tick and in_stall_o rises only once both are full.
//   pkt_delay is written through cfg_we_i/cfg_data_i while idle (a user rule, not
//   enforced by the block); the write registers the interval limit pkt_delay*100.
//   Reset (rst_ni low, async): all counters, flags and key state go to zero,
//   pkt_delay returns to 10, both stages empty.
module tick_key_debounce_packet_timer_top #(
  parameter int unsigned KEY_WINDOW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tkdb_pkg::tkdb_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tkdb_pkg::tkdb_out_t out_data_o
);
  import tkdb_pkg::*;

  localparam int unsigned WinW = $clog2(KEY_WINDOW + 1);
  localparam logic [WinW-1:0]   WinLast  = WinW'(KEY_WINDOW);
  localparam logic [IntegW-1:0] KeyThres = IntegW'(KEY_WINDOW / 2);

  // pipeline control
  logic      s1_valid_q;
  tkdb_in_t  s1_data_q;
  logic      out_valid_q;
  tkdb_out_t out_data_q;
  logic      out_ready;
  logic      s1_fire;

  // block state
  logic [PktW-1:0]   pkt_limit_q;
  logic [15:0]       delay_left_q, delay_left_d;
  logic [15:0]       rx_ticks_q, rx_ticks_d;
  logic [PktW-1:0]   pkt_ticks_q, pkt_ticks_d;
  logic              pkt_pend_q, pkt_pend_d;
  logic [IntegW-1:0] integ0_q, integ0_d, integ1_q, integ1_d;
  logic [WinW-1:0]   win_ticks_q, win_ticks_d;
  logic [1:0]        key_state_q, key_state_d;
  logic              wend;

  assign out_ready   = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && out_ready;
  assign in_stall_o  = s1_valid_q && !out_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  function automatic logic [IntegW-1:0] integrate(logic [IntegW-1:0] acc, logic level);
    logic [IntegW-1:0] r;
    r = acc;
    if (!level) begin
      if (acc != IntegMax) r = acc + IntegW'(1);
    end else begin
      if (acc != '0) r = acc - IntegW'(1);
    end
    return r;
  endfunction

  logic [WinW-1:0]   win_inc;
  logic [PktW-1:0]   pkt_inc;
  logic [15:0]       rx_base;

  always_comb begin
    // delay: a load of n reads n after this tick (0xFFFF saturates then counts once)
    if (s1_data_q.load_delay) begin
      delay_left_d = (s1_data_q.delay_count == 16'hFFFF) ? 16'hFFFE : s1_data_q.delay_count;
    end else begin
      delay_left_d = (delay_left_q != '0) ? delay_left_q - 16'd1 : '0;
    end

    rx_base    = s1_data_q.clear_rx_timeout ? '0 : rx_ticks_q;
    rx_ticks_d = rx_base + 16'd1;

    integ0_d = integrate(integ0_q, s1_data_q.key0_level);
    integ1_d = integrate(integ1_q, s1_data_q.key1_level);

    win_inc     = win_ticks_q + WinW'(1);
    wend        = (win_inc >= WinLast);
    win_ticks_d = wend ? '0 : win_inc;
    key_state_d = wend ? {(integ1_d >= KeyThres), (integ0_d >= KeyThres)} : key_state_q;

    // packet timer: counter stays below the largest limit 255*100, so +1 cannot wrap
    pkt_inc    = pkt_ticks_q + PktW'(1);
    pkt_pend_d = s1_data_q.clear_packet_flag ? 1'b0 : pkt_pend_q;
    if (pkt_inc >= pkt_limit_q) begin
      pkt_ticks_d = '0;
      pkt_pend_d  = 1'b1;
    end else begin
      pkt_ticks_d = pkt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      pkt_limit_q  <= PktLimitRst;
      delay_left_q <= '0;
      rx_ticks_q   <= '0;
      pkt_ticks_q  <= '0;
      pkt_pend_q   <= 1'b0;
      integ0_q     <= '0;
      integ1_q     <= '0;
      win_ticks_q  <= '0;
      key_state_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        pkt_limit_q <= PktW'(cfg_data_i * PktW'(PktUnit));
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        delay_left_q <= delay_left_d;
        rx_ticks_q   <= rx_ticks_d;
        pkt_ticks_q  <= pkt_ticks_d;
        pkt_pend_q   <= pkt_pend_d;
        integ0_q     <= integ0_d;
        integ1_q     <= integ1_d;
        win_ticks_q  <= win_ticks_d;
        key_state_q  <= key_state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (s1_fire) begin
      out_data_q.key_code         <= key_state_d;
      out_data_q.window_end       <= wend;
      out_data_q.packet_flag      <= pkt_pend_d;
      out_data_q.delay_busy       <= (delay_left_d != '0);
      out_data_q.rx_timeout_count <= rx_ticks_d;
    end
  end

endmodule

### rtl/tkdb_checker.sv
// Checker: port-level assertions for the debouncer / packet timer, with bind.
module tkdb_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tkdb_pkg::tkdb_out_t out_data_o
);
  import tkdb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // input back-pressure only when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  // an empty output side never blocks the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  // a released output stall lifts the input back-pressure
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input still stalled after output drained");

endmodule

bind tick_key_debounce_packet_timer_top tkdb_checker u_tkdb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

### test/testbench.sv
// Self-checking testbench for the tick-driven key debouncer and packet timer.
`timescale 1ns / 100ps

module testbench;
  import tkdb_pkg::*;

  // Debounce window; the block is built with the same value.
  localparam int unsigned KeyWindow  = 16;
  localparam int unsigned KeyHalf    = KeyWindow / 2;
  localparam int unsigned HalfPeriod = 6;          // 12 ns clock
  localparam int unsigned TailCycles = 6;          // drain margin after the last result
  localparam int unsigned HoldOffLen = 80;         // long receiver hold-off

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      cfg_we     = 1'b0;
  logic [7:0] cfg_data  = 8'd0;
  logic      in_valid   = 1'b0;
  tkdb_in_t  in_data    = '0;
  logic      out_stall  = 1'b0;
  logic      in_stall;
  logic      out_valid;
  tkdb_out_t out_data;

  tick_key_debounce_packet_timer_top #(
    .KEY_WINDOW (KeyWindow)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always #(HalfPeriod) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow state of the block. Updated once per accepted tick, in tick order.
  // ---------------------------------------------------------------------------
  logic [7:0]  pkt_delay_sh = PktDelayRst;  // shadow of the interval register
  logic [15:0] dly_left     = '0;
  logic [15:0] rx_cnt       = '0;
  logic [15:0] pkt_cnt      = '0;
  logic        pkt_pend     = 1'b0;
  logic [6:0]  integ [2]    = '{7'd0, 7'd0};
  logic [7:0]  win_cnt      = '0;
  logic [1:0]  keys_q       = '0;

  tkdb_out_t pending_results [$];   // expected results, oldest first

  int errors          = 0;
  int ticks_sent      = 0;
  int results_seen    = 0;
  int in_stall_cycles = 0;
  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  bit hold_req        = 1'b0;
  int hold_cnt        = 0;

  // One millisecond tick: strobes first, then counters, keys and packet timer.
  function automatic tkdb_out_t advance_tick(tkdb_in_t t);
    tkdb_out_t  r;
    logic [1:0] lvl;
    r = '0;
    if (t.clear_rx_timeout)  rx_cnt = '0;
    if (t.clear_packet_flag) pkt_pend = 1'b0;
    // delay_count + 1 saturates at the top of the range
    if (t.load_delay)
      dly_left = (t.delay_count == 16'hFFFF) ? 16'hFFFF : t.delay_count + 16'd1;

    if (dly_left != 16'd0) dly_left = dly_left - 16'd1;  // parks at zero
    rx_cnt = rx_cnt + 16'd1;

    // Integrators: up while pressed (pin low), down while released, clamped.
    lvl = {t.key1_level, t.key0_level};
    for (int k = 0; k < 2; k++) begin
      if (!lvl[k]) begin
        if (integ[k] < IntegMax) integ[k] = integ[k] + 7'd1;
      end else if (integ[k] != 7'd0) begin
        integ[k] = integ[k] - 7'd1;
      end
    end
    win_cnt = win_cnt + 8'd1;
    if (win_cnt >= KeyWindow) begin
      win_cnt      = '0;
      keys_q       = {integ[1] >= KeyHalf, integ[0] >= KeyHalf};
      r.window_end = 1'b1;
    end

    // Interval compare uses >= so a lowered interval fires on the next tick.
    pkt_cnt = pkt_cnt + 16'd1;
    if (32'(pkt_cnt) >= 32'(pkt_delay_sh) * PktUnit) begin
      pkt_cnt  = '0;
      pkt_pend = 1'b1;
    end

    r.key_code         = keys_q;
    r.packet_flag      = pkt_pend;
    r.delay_busy       = (dly_left != 16'd0);
    r.rx_timeout_count = rx_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: every accepted tick feeds the shadow model. Sampled in the
  // active region of the edge, so these are the pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid) begin
      if (in_stall) begin
        in_stall_cycles++;
      end else begin
        pending_results.push_back(advance_tick(in_data));
        ticks_sent++;
      end
    end
  end

  // Receiver stall pattern; a hold-off request forces a long stall run.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldOffLen;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Output side: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    tkdb_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.key_code !== want.key_code) begin
          $error("key_code: expected %0d, actual %0d", want.key_code, out_data.key_code);
          errors++;
        end
        if (out_data.window_end !== want.window_end) begin
          $error("window_end: expected %0d, actual %0d",
                 want.window_end, out_data.window_end);
          errors++;
        end
        if (out_data.packet_flag !== want.packet_flag) begin
          $error("packet_flag: expected %0d, actual %0d",
                 want.packet_flag, out_data.packet_flag);
          errors++;
        end
        if (out_data.delay_busy !== want.delay_busy) begin
          $error("delay_busy: expected %0d, actual %0d",
                 want.delay_busy, out_data.delay_busy);
          errors++;
        end
        if (out_data.rx_timeout_count !== want.rx_timeout_count) begin
          $error("rx_timeout_count: expected %0d, actual %0d",
                 want.rx_timeout_count, out_data.rx_timeout_count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver helpers
  // ---------------------------------------------------------------------------

  // Offer one tick and hold it until the block takes it, then maybe go idle.
  task automatic send_tick(input tkdb_in_t t);
    int gap;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid (only one assignment in this step) and wait out all results.
  // It waits for a clock edge before checking the queue, so the last accepted tick is already queued.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
  endtask

  // Register write; only called once the block has drained.
  task automatic write_pkt_delay(input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    pkt_delay_sh = v;
    cfg_we   <= 1'b0;
  endtask

  function automatic tkdb_in_t make_tick(input logic [1:0] keys, input logic load,
                                         input logic [15:0] cnt, input logic clr_rx,
                                         input logic clr_pkt);
    tkdb_in_t t;
    t.key0_level        = keys[0];
    t.key1_level        = keys[1];
    t.load_delay        = load;
    t.delay_count       = cnt;
    t.clear_rx_timeout  = clr_rx;
    t.clear_packet_flag = clr_pkt;
    return t;
  endfunction

  // Random strobes on top of the given key levels; loads are rare, with short,
  // full-range and edge values so the busy flag goes both ways.
  function automatic tkdb_in_t random_tick(input logic [1:0] keys);
    logic [15:0] cnt;
    case ($urandom_range(0, 9))
      0:       cnt = 16'hFFFF;
      1:       cnt = 16'hFFFE;
      2, 3, 4: cnt = 16'($urandom_range(0, 40));
      default: cnt = 16'($urandom);
    endcase
    return make_tick(keys, $urandom_range(0, 15) == 0, cnt,
                     $urandom_range(0, 31) == 0, $urandom_range(0, 19) == 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Delay load edges, clears and key extremes under the reset interval.
  task automatic test_timer_strobes;
    send_tick(make_tick(2'b00, 1'b1, 16'hFFFF, 1'b0, 1'b0));  // load saturates
    send_tick(make_tick(2'b00, 1'b1, 16'hFFFE, 1'b0, 1'b0));
    send_tick(make_tick(2'b00, 1'b1, 16'd0,    1'b0, 1'b0));  // load 0: not busy
    send_tick(make_tick(2'b00, 1'b1, 16'd1,    1'b0, 1'b0));
    send_tick(make_tick(2'b00, 1'b0, 16'd0,    1'b0, 1'b0));  // counter parks at 0
    send_tick(make_tick(2'b00, 1'b0, 16'd0,    1'b0, 1'b0));
    send_tick(make_tick(2'b11, 1'b0, 16'd0,    1'b1, 1'b0));  // clear rx count
    send_tick(make_tick(2'b11, 1'b0, 16'd0,    1'b0, 1'b1));
    send_tick(make_tick(2'b10, 1'b0, 16'd0,    1'b0, 1'b0));  // key 0 only
    send_tick(make_tick(2'b01, 1'b0, 16'd0,    1'b0, 1'b0));  // key 1 only
    send_tick(make_tick(2'b11, 1'b1, 16'hFFFF, 1'b1, 1'b1));  // every strobe
    drain();
  endtask

  // Zero interval fires every tick, even when cleared on that tick; the top
  // interval then clears the flag without firing.
  task automatic test_packet_interval;
    write_pkt_delay(8'd0);
    send_tick(make_tick(2'b11, 1'b0, 16'd0, 1'b0, 1'b0));
    send_tick(make_tick(2'b11, 1'b0, 16'd0, 1'b0, 1'b1));
    send_tick(make_tick(2'b00, 1'b0, 16'd0, 1'b0, 1'b0));
    drain();
    write_pkt_delay(8'd255);
    send_tick(make_tick(2'b00, 1'b0, 16'd0, 1'b0, 1'b1));
    send_tick(make_tick(2'b11, 1'b0, 16'd0, 1'b0, 1'b0));
    drain();
  endtask

  // Key press runs with bounce, plus some pure noise runs. Long runs drive the
  // integrators into both clamps.
  task automatic run_key_traffic(input int n);
    int         sent;
    int         run_len;
    bit         noisy;
    logic [1:0] lvl;
    logic [1:0] keys;
    sent = 0;
    while (sent < n) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(130, 300)
                                            : $urandom_range(1, 60);
      lvl     = 2'($urandom_range(0, 3));
      noisy   = ($urandom_range(0, 5) == 0);
      for (int j = 0; j < run_len && sent < n; j++) begin
        if (noisy) keys = 2'($urandom_range(0, 3));
        else if ($urandom_range(0, 11) == 0) keys = lvl ^ 2'($urandom_range(1, 3));
        else keys = lvl;
        send_tick(random_tick(keys));
        sent++;
      end
    end
    drain();
  endtask

  // Four idling phases. The 255 phase leaves the packet timer past 100, so
  // lowering to 1 exercises the lowered-interval case on the next tick.
  task automatic test_random_phases;
    send_idle_pct = 0;  recv_stall_pct = 0;
    write_pkt_delay(8'd255);
    run_key_traffic(500);

    send_idle_pct = 78; recv_stall_pct = 0;
    write_pkt_delay(8'd1);
    run_key_traffic(500);

    send_idle_pct = 0;  recv_stall_pct = 78;
    write_pkt_delay(8'd2);
    run_key_traffic(500);

    send_idle_pct = 12; recv_stall_pct = 12;
    write_pkt_delay(8'($urandom_range(0, 255)));
    run_key_traffic(500);
  endtask

  // Receiver holds off for a long stretch while ticks keep coming, so both
  // pipeline stages fill and the input side stalls.
  task automatic test_backpressure;
    send_idle_pct = 0; recv_stall_pct = 0;
    write_pkt_delay(8'd0);
    hold_req = 1'b1;
    run_key_traffic(40);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_timer_strobes();
    test_packet_interval();
    test_random_phases();
    test_backpressure();

    $display("Checked %0d ticks and %0d results over four idling phases and a hold-off",
             ticks_sent, results_seen);
    $display("(interval settings 10, 0, 255, 1, 2 and random; %0d input stall cycles)",
             in_stall_cycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #6_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
